[hw/rtl/aabb_pkg.sv]
// shared types and constants for the aabb pair overlap finder
`timescale 1ns / 1ps

package aabb_pkg;

  localparam int MAX_BOXES   = 64;
  localparam int COORD_WIDTH = 32;
  localparam int ADDR_W      = $clog2(MAX_BOXES);
  localparam int CNT_W       = $clog2(MAX_BOXES + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic               frame_start;
    logic        [31:0] entity_id;
    logic signed [31:0] low_x;
    logic signed [31:0] low_y;
    logic signed [31:0] low_z;
    logic signed [31:0] high_x;
    logic signed [31:0] high_y;
    logic signed [31:0] high_z;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] earlier_entity;
    logic [31:0] later_entity;
    logic        last_of_run;
    logic        store_overflow;
  } out_item_t;

  typedef struct packed {
    logic [31:0] entity;
    coord_t      lo_x;
    coord_t      lo_y;
    coord_t      lo_z;
    coord_t      hi_x;
    coord_t      hi_y;
    coord_t      hi_z;
  } box_t;

  typedef struct packed {
    logic frame_start;
    box_t box;
  } front_item_t;

endpackage

[hw/rtl/aabb_front.sv]
// input stage: takes boxes, repacks them and queues them for the sweep engine
`timescale 1ns / 1ps

module aabb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aabb_pkg::in_item_t    in_data,
  output logic                  q_valid,
  input  logic                  q_ready,
  output aabb_pkg::front_item_t q_data
);
  import aabb_pkg::*;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  front_item_t           queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [QCNT_W-1:0]     fill;
  front_item_t           item;
  logic                  push;
  logic                  pop;

  always_comb begin
    item.frame_start = in_data.frame_start;
    item.box.entity  = in_data.entity_id;
    item.box.lo_x    = in_data.low_x[COORD_WIDTH-1:0];
    item.box.lo_y    = in_data.low_y[COORD_WIDTH-1:0];
    item.box.lo_z    = in_data.low_z[COORD_WIDTH-1:0];
    item.box.hi_x    = in_data.high_x[COORD_WIDTH-1:0];
    item.box.hi_y    = in_data.high_y[COORD_WIDTH-1:0];
    item.box.hi_z    = in_data.high_z[COORD_WIDTH-1:0];
  end

  assign in_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign q_data   = queue[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill above depth");

endmodule

[hw/rtl/aabb_back.sv]
// sweep engine: compares a box with the stored boxes, emits pairs and stores the box while the store has room
`timescale 1ns / 1ps

module aabb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  aabb_pkg::front_item_t q_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aabb_pkg::out_item_t   out_data
);
  import aabb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FLUSH
  } state_t;

  state_t              state;
  box_t                mem [MAX_BOXES];
  box_t                rd_data;
  box_t                cur;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [CNT_W-1:0]    box_count;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    n_sel;
  logic [ADDR_W-1:0]   idx;
  logic                ovf;
  logic                pend_vld;
  logic [31:0]         pend_id;
  logic                out_free;
  logic                hit;
  logic                stall;
  logic                last_entry;

  assign out_free   = !out_valid || out_ready;
  assign n_sel      = q_data.frame_start ? '0 : box_count;
  assign last_entry = (CNT_W'(idx) + CNT_W'(1)) == n;
  assign q_ready    = (state == S_IDLE);

  always_comb begin
    hit = (rd_data.entity != cur.entity)
       && !(cur.lo_x > rd_data.hi_x || cur.lo_y > rd_data.hi_y || cur.lo_z > rd_data.hi_z)
       && !(rd_data.lo_x > cur.hi_x || rd_data.lo_y > cur.hi_y || rd_data.lo_z > cur.hi_z);
  end

  assign stall = hit && pend_vld && !out_free;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        rd_en = q_valid && (n_sel != '0);
      end
      S_SWEEP: begin
        rd_en   = !stall && !last_entry;
        rd_addr = idx + ADDR_W'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en = (state == S_FLUSH) && out_free && !ovf;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[n[ADDR_W-1:0]] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend_vld  <= 1'b0;
      box_count <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_data.box;
            n         <= n_sel;
            box_count <= n_sel;
            ovf       <= (n_sel == CNT_W'(MAX_BOXES));
            idx       <= '0;
            pend_vld  <= 1'b0;
            state     <= (n_sel == '0) ? S_FLUSH : S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (!stall) begin
            if (hit) begin
              if (pend_vld) begin
                out_valid <= 1'b1;
                out_data  <= '{hit: 1'b1, earlier_entity: pend_id,
                               later_entity: cur.entity, last_of_run: 1'b0,
                               store_overflow: ovf};
              end
              pend_vld <= 1'b1;
              pend_id  <= rd_data.entity;
            end
            if (last_entry) begin
              state <= S_FLUSH;
            end else begin
              idx <= idx + ADDR_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (pend_vld) begin
              out_data <= '{hit: 1'b1, earlier_entity: pend_id,
                            later_entity: cur.entity, last_of_run: 1'b1,
                            store_overflow: ovf};
            end else begin
              out_data <= '{hit: 1'b0, earlier_entity: 32'd0,
                            later_entity: cur.entity, last_of_run: 1'b1,
                            store_overflow: ovf};
            end
            pend_vld <= 1'b0;
            if (!ovf) begin
              box_count <= n + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    box_count <= CNT_W'(MAX_BOXES))
    else $error("box count above store size");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_vld)
    else $error("pending pair left over between boxes");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (CNT_W'(idx) < n))
    else $error("sweep index past stored boxes");

  a_miss_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |-> out_data.last_of_run)
    else $error("miss result not marked last");

endmodule

[hw/rtl/aabb_pair_overlap_finder.sv]
// top level of the all-pairs 3d box overlap finder
// the sweep engine reads the box store one entry per cycle, holding while the result side
//   stalls, and takes the next box only once the current one is finished; the store holds
//   up to 64 boxes
// a two-entry input queue takes new boxes while the sweep engine works
// reset: synchronous, clears the stored box count, the queue and all valid flags; no store sweep
`timescale 1ns / 1ps

module aabb_pair_overlap_finder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  aabb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aabb_pkg::out_item_t out_data
);
  import aabb_pkg::*;

  logic        q_valid;
  logic        q_ready;
  front_item_t q_data;

  aabb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  aabb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
